// File: sv/smdc_pkg.sv
// ----------------------------------------------------------------------------
// smdc_pkg - shared types and constants for the microstep coil driver
// Field widths, motor geometry and command codes used by all driver modules.
// ----------------------------------------------------------------------------
package smdc_pkg;

    // Motor geometry
    localparam int COILS         = 4;
    localparam int TEETH         = 8;
    localparam int GEARING       = 64;
    localparam int FRACTION_BITS = 8;

    // One revolution in microstep units (power of two for this geometry)
    localparam int REV_UNITS = COILS * TEETH * GEARING * (2 ** FRACTION_BITS);
    localparam int POS_W     = $clog2(REV_UNITS);

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int AMOUNT_W = 20;
    localparam int DUTY_W   = 8;
    localparam int COIL_W   = $clog2(COILS);

    // Stream packing widths (whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 8'd255;

    typedef logic [DUTY_W-1:0] duty_t;
    typedef duty_t [COILS-1:0] duty_vec_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET     = 2'd0,
        OP_MOVE    = 2'd1,
        OP_HOLD    = 2'd2,
        OP_RELEASE = 2'd3
    } opcode_t;

endpackage

// File: sv/smdc_hold.sv
// ----------------------------------------------------------------------------
// smdc_hold - hold pattern duty generator
// Splits max duty between the current coil and the next one by the step
// fraction of the rotor position. Purely combinational.
// ----------------------------------------------------------------------------
module smdc_hold
    import smdc_pkg::*;
(
    input  logic [POS_W-1:0]  place,
    input  duty_t             max_duty,
    output duty_vec_t         duty
);

    logic [FRACTION_BITS-1:0]                frac;
    logic [COIL_W-1:0]                       base;
    logic [COIL_W-1:0]                       next_coil;
    logic [FRACTION_BITS:0]                  weight_base;
    logic [FRACTION_BITS+DUTY_W:0]           prod_base;
    logic [FRACTION_BITS+DUTY_W:0]           prod_next;
    duty_t                                   duty_base;
    duty_t                                   duty_next;

    // Whole step mod coil count, and fraction of a step
    assign frac      = place[FRACTION_BITS-1:0];
    assign base      = place[FRACTION_BITS +: COIL_W];
    assign next_coil = base + COIL_W'(1);

    // (1 - f) * max and f * max, truncated; f == 0 gives max on base coil
    assign weight_base = (FRACTION_BITS+1)'(2 ** FRACTION_BITS) - {1'b0, frac};
    assign prod_base   = (FRACTION_BITS+DUTY_W+1)'(weight_base * max_duty);
    assign prod_next   = (FRACTION_BITS+DUTY_W+1)'({1'b0, frac} * max_duty);
    assign duty_base   = prod_base[FRACTION_BITS +: DUTY_W];
    assign duty_next   = prod_next[FRACTION_BITS +: DUTY_W];

    // Place the two duties on their coils
    always_comb
    begin
        for (int c = 0; c < COILS; c++)
        begin
            if (COIL_W'(c) == base)
                duty[c] = duty_base;
            else if (COIL_W'(c) == next_coil)
                duty[c] = duty_next;
            else
                duty[c] = '0;
        end
    end

endmodule

// File: sv/stepper_microstep_coil_driver.sv
// ----------------------------------------------------------------------------
// stepper_microstep_coil_driver - four-coil microstep position and duty unit
// Tracks a wrapped rotor position and produces per-coil drive duties.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser carries the command (set, move, hold, release),
//   s_tdata the signed amount in 1/256 step units. Each accepted item yields
//   exactly one result item on m_*: four coil duties and the wrapped rotor
//   position after the item.
//   max_duty_we/max_duty_wdata write the full-drive duty; write only while
//   no item is in flight.
//   An accepted item sits in the input register, moves to the result
//   register once that is free and is offered on m_tvalid from then on.
//   Throughput is one item per cycle while results are taken; the add/wrap of
//   the position and two 9x8 duty multiplies sit between the two registers.
//   When m_tready is low a full result register holds; the input register can
//   still fill, after which s_tready drops until the result is taken.
//   Reset clears the position to zero, max duty to 255, and empties both
//   registers.
// ----------------------------------------------------------------------------
module stepper_microstep_coil_driver
    import smdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [19:0] amount, rest zero
    input  logic [OPCODE_W-1:0]   s_tuser,   // [1:0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // coil0..coil3 duty, rotor_position
    input  logic                  max_duty_we,
    input  logic [DUTY_W-1:0]     max_duty_wdata
);

    logic                        in_valid_reg;
    opcode_t                     in_op_reg;
    logic signed [AMOUNT_W-1:0]  in_amount_reg;
    logic                        out_valid_reg;
    duty_vec_t                   out_duty_reg;
    logic [POS_W-1:0]            out_pos_reg;
    logic [POS_W-1:0]            rotor_place_reg;
    logic [POS_W-1:0]            rotor_place_next;
    duty_t                       max_duty_reg;

    logic                        advance;
    logic [AMOUNT_W:0]           pos_sum;
    duty_vec_t                   hold_duty;
    duty_vec_t                   duty_next;

    // Handshake: result stage frees when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_duty_reg <= MAX_DUTY_RESET;
        else if (max_duty_we)
            max_duty_reg <= max_duty_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg     <= opcode_t'(s_tuser);
            in_amount_reg <= s_tdata[AMOUNT_W-1:0];
        end
    end

    // Position update; revolution is a power of two so wrap is a truncation
    always_comb
    begin
        pos_sum          = '0;
        rotor_place_next = rotor_place_reg;
        unique case (in_op_reg)
            OP_SET:
            begin
                pos_sum          = (AMOUNT_W+1)'(in_amount_reg);
                rotor_place_next = pos_sum[POS_W-1:0];
            end
            OP_MOVE:
            begin
                pos_sum          = (AMOUNT_W+1)'(rotor_place_reg)
                                 + (AMOUNT_W+1)'(in_amount_reg);
                rotor_place_next = pos_sum[POS_W-1:0];
            end
            OP_HOLD, OP_RELEASE:
            begin
                rotor_place_next = rotor_place_reg;
            end
            default:
            begin
                rotor_place_next = rotor_place_reg;
            end
        endcase
    end

    // Hold pattern from current position
    smdc_hold u_hold (
        .place    (rotor_place_reg),
        .max_duty (max_duty_reg),
        .duty     (hold_duty)
    );

    assign duty_next = (in_op_reg == OP_HOLD) ? hold_duty : '0;

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rotor_place_reg <= '0;
        else if (advance && in_valid_reg)
            rotor_place_reg <= rotor_place_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_duty_reg <= duty_next;
            out_pos_reg  <= rotor_place_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - COILS*DUTY_W - POS_W)'(0), out_pos_reg,
                       out_duty_reg[3], out_duty_reg[2], out_duty_reg[1],
                       out_duty_reg[0]};

    // Checks
    a_two_coils_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({out_duty_reg[0] != '0, out_duty_reg[1] != '0,
                                 out_duty_reg[2] != '0, out_duty_reg[3] != '0}) <= 2)
        else $error("more than two coils driven");

    a_duty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((DUTY_W+2)'(out_duty_reg[0]) + (DUTY_W+2)'(out_duty_reg[1])
                    + (DUTY_W+2)'(out_duty_reg[2]) + (DUTY_W+2)'(out_duty_reg[3]))
                    <= (DUTY_W+2)'(max_duty_reg))
        else $error("coil duties exceed max duty");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (in_op_reg == OP_HOLD || in_op_reg == OP_RELEASE))
        |=> $stable(rotor_place_reg))
        else $error("position changed on hold or release");

    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> (out_pos_reg == rotor_place_reg))
        else $error("reported position differs from state");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule
